// ----- hdl/cpbgra_pkg.sv -----
// Package for the camera pixel to BGRA converter: format codes, pixel and
// result types, BT.601 coefficients. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpbgra_pkg;

  typedef enum logic [2:0] {
    FMT_BGR888    = 3'd0,
    FMT_RGB888    = 3'd1,
    FMT_BGRX_COPY = 3'd2,
    FMT_RGBX_SWAP = 3'd3,
    FMT_LUMA      = 3'd4,
    FMT_YUYV      = 3'd5
  } fmt_e;

  localparam int unsigned SumW = 20;

  localparam logic signed [SumW-1:0] KY     = 20'sd298;
  localparam logic signed [SumW-1:0] KUB    = 20'sd516;
  localparam logic signed [SumW-1:0] KUG    = 20'sd100;
  localparam logic signed [SumW-1:0] KVG    = 20'sd208;
  localparam logic signed [SumW-1:0] KVR    = 20'sd409;
  localparam logic signed [SumW-1:0] Round  = 20'sd128;
  localparam logic signed [SumW-1:0] YOfs   = 20'sd16;
  localparam logic signed [SumW-1:0] UvOfs  = 20'sd128;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [1:0] CountOne    = 2'd1;
  localparam logic [1:0] CountTwo    = 2'd2;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t     pix0;
    pixel_t     pix1;
    logic [1:0] count;
  } result_t;

  // floor shift by 8 then limit to 0..255
  function automatic logic [7:0] clamp_shift8(logic signed [SumW-1:0] sum);
    logic [7:0] res;
    if (sum[SumW-1]) begin
      res = 8'd0;
    end else if (|sum[SumW-2:16]) begin
      res = 8'd255;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/camera_pixel_to_bgra_converter_top.sv -----
// Camera pixel to BGRA converter, top level: format register, input word
// register, result register and valid/stall flow. Depends on cpbgra_pkg
// and cpbgra_fmt_mux.
// Path: input word register, format mux, result register.
// Throughput: one word per cycle while out_stall_i is low; each register
// refills in the cycle it drains, and in_stall_o is set only when both are
// full with out_stall_i high. Reset: asynchronous, active low; clears both
// valid flags and sets the source format to luma.
`timescale 1ns / 1ps
`default_nettype none

module camera_pixel_to_bgra_converter_top
  import cpbgra_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,

  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] src_byte0_i,
  input  wire logic [7:0] src_byte1_i,
  input  wire logic [7:0] src_byte2_i,
  input  wire logic [7:0] src_byte3_i,

  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      pix0_blue_o,
  output logic [7:0]      pix0_green_o,
  output logic [7:0]      pix0_red_o,
  output logic [7:0]      pix0_alpha_o,
  output logic [7:0]      pix1_blue_o,
  output logic [7:0]      pix1_green_o,
  output logic [7:0]      pix1_red_o,
  output logic [7:0]      pix1_alpha_o,
  output logic [1:0]      pixel_count_o
);

  logic [2:0] fmt_q;
  logic       in_vld_q;
  logic [7:0] b0_q, b1_q, b2_q, b3_q;
  logic       out_vld_q;
  result_t    res_q, res_d;
  logic       out_adv, in_adv;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign in_adv     = !in_vld_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_LUMA;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= in_valid_i;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      b0_q <= src_byte0_i;
      b1_q <= src_byte1_i;
      b2_q <= src_byte2_i;
      b3_q <= src_byte3_i;
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  cpbgra_fmt_mux u_fmt_mux (
    .fmt_i (fmt_q),
    .b0_i  (b0_q),
    .b1_i  (b1_q),
    .b2_i  (b2_q),
    .b3_i  (b3_q),
    .res_o (res_d)
  );

  assign out_valid_o   = out_vld_q;
  assign pix0_blue_o   = res_q.pix0.blue;
  assign pix0_green_o  = res_q.pix0.green;
  assign pix0_red_o    = res_q.pix0.red;
  assign pix0_alpha_o  = res_q.pix0.alpha;
  assign pix1_blue_o   = res_q.pix1.blue;
  assign pix1_green_o  = res_q.pix1.green;
  assign pix1_red_o    = res_q.pix1.red;
  assign pix1_alpha_o  = res_q.pix1.alpha;
  assign pixel_count_o = res_q.count;

endmodule

`default_nettype wire

// ----- hdl/cpbgra_yuv_pix.sv -----
// One BT.601 YUV to BGRA pixel: constant-coefficient sums and clamp.
// Depends on cpbgra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpbgra_yuv_pix
  import cpbgra_pkg::*;
(
  input  wire logic [7:0] luma_i,
  input  wire logic [7:0] u_i,
  input  wire logic [7:0] v_i,
  output pixel_t          pix_o
);

  logic signed [SumW-1:0] c_s, d_s, e_s, yc_s;
  logic signed [SumW-1:0] sum_b, sum_g, sum_r;

  always_comb begin
    c_s  = signed'(SumW'(luma_i)) - YOfs;
    d_s  = signed'(SumW'(u_i)) - UvOfs;
    e_s  = signed'(SumW'(v_i)) - UvOfs;
    yc_s = c_s * KY;
    sum_b = yc_s + d_s * KUB + Round;
    sum_g = yc_s - d_s * KUG - e_s * KVG + Round;
    sum_r = yc_s + e_s * KVR + Round;
    pix_o.blue  = clamp_shift8(sum_b);
    pix_o.green = clamp_shift8(sum_g);
    pix_o.red   = clamp_shift8(sum_r);
    pix_o.alpha = AlphaOpaque;
  end

endmodule

`default_nettype wire

// ----- hdl/cpbgra_fmt_mux.sv -----
// Format decode: byte shuffles, luma replicate and the two YUYV pixels.
// Depends on cpbgra_pkg and cpbgra_yuv_pix.
`timescale 1ns / 1ps
`default_nettype none

module cpbgra_fmt_mux
  import cpbgra_pkg::*;
(
  input  wire logic [2:0] fmt_i,
  input  wire logic [7:0] b0_i,
  input  wire logic [7:0] b1_i,
  input  wire logic [7:0] b2_i,
  input  wire logic [7:0] b3_i,
  output result_t         res_o
);

  pixel_t yuv0, yuv1;

  cpbgra_yuv_pix u_yuv0 (
    .luma_i (b0_i),
    .u_i    (b1_i),
    .v_i    (b3_i),
    .pix_o  (yuv0)
  );

  cpbgra_yuv_pix u_yuv1 (
    .luma_i (b2_i),
    .u_i    (b1_i),
    .v_i    (b3_i),
    .pix_o  (yuv1)
  );

  always_comb begin
    res_o.pix0  = '{blue: b0_i, green: b0_i, red: b0_i, alpha: AlphaOpaque};
    res_o.pix1  = '0;
    res_o.count = CountOne;
    unique case (fmt_e'(fmt_i))
      FMT_BGR888: begin
        res_o.pix0 = '{blue: b0_i, green: b1_i, red: b2_i, alpha: AlphaOpaque};
      end
      FMT_RGB888, FMT_RGBX_SWAP: begin
        res_o.pix0 = '{blue: b2_i, green: b1_i, red: b0_i, alpha: AlphaOpaque};
      end
      FMT_BGRX_COPY: begin
        res_o.pix0 = '{blue: b0_i, green: b1_i, red: b2_i, alpha: b3_i};
      end
      FMT_YUYV: begin
        res_o.pix0  = yuv0;
        res_o.pix1  = yuv1;
        res_o.count = CountTwo;
      end
      default: begin
        // luma and unknown codes: replicate byte 0
        res_o.pix0 = '{blue: b0_i, green: b0_i, red: b0_i, alpha: AlphaOpaque};
      end
    endcase
  end

endmodule

`default_nettype wire
